>>> hdl/sld_pkg.sv
// shared types and constants for the sync length frame deframer
`default_nettype none

package sld_pkg;

    localparam int unsigned MAX_PARAMS = 72;
    localparam int unsigned HDR_LEN    = 4;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] LEN_MIN    = 8'(HDR_LEN);
    localparam logic [7:0] LEN_MAX    = 8'(MAX_PARAMS + HDR_LEN);

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_SECOND = 3'd1,
        ST_LEN    = 3'd2,
        ST_CMD    = 3'd3,
        ST_PARAMS = 3'd4,
        ST_CKSUM  = 3'd5
    } t_parse_state;

    typedef enum logic [1:0] {
        KIND_PARAM = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] command;
        logic [6:0] param_count;
        logic [6:0] param_index;
        logic [7:0] data;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/sld_in_stage.sv
// input register: holds one received byte until the parser takes it
`default_nettype none

module sld_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    input  wire logic       i_take,
    output logic [7:0]      o_byte
);
    import sld_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // register is free when empty or being drained this cycle
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

>>> hdl/sld_parser.sv
// frame parser: header hunt, length check, parameter tagging, checksum verdict
`default_nettype none

module sld_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    output logic               o_res_valid,
    output sld_pkg::t_result   o_res
);
    import sld_pkg::*;

    t_parse_state r_state, n_state;
    logic [6:0]   r_len, n_len;
    logic [7:0]   r_cmd, n_cmd;
    logic [6:0]   r_seen, n_seen;
    logic [7:0]   r_sum, n_sum;
    logic [6:0]   seen_inc;
    logic [7:0]   sum_add;

    assign seen_inc = r_seen + 7'd1;
    assign sum_add  = r_sum + i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_len   <= '0;
            r_cmd   <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cmd       = r_cmd;
        n_seen      = r_seen;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res.kind        = KIND_PARAM;
        o_res.command     = r_cmd;
        o_res.param_count = r_len - 7'(HDR_LEN);
        o_res.param_index = '0;
        o_res.data        = i_byte;
        case (r_state)
            ST_HUNT: begin
                if (i_byte == HDR_FIRST) begin
                    n_sum   = i_byte;
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: begin
                if (i_byte == HDR_SECOND) begin
                    n_sum   = sum_add;
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_LEN: begin
                if (i_byte < LEN_MIN || i_byte > LEN_MAX) begin
                    n_state = ST_HUNT;
                end else begin
                    n_len   = i_byte[6:0];
                    n_sum   = sum_add;
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                n_cmd   = i_byte;
                n_sum   = sum_add;
                n_seen  = '0;
                n_state = (r_len > 7'(HDR_LEN)) ? ST_PARAMS : ST_CKSUM;
            end
            ST_PARAMS: begin
                o_res_valid       = 1'b1;
                o_res.param_index = r_seen;
                n_sum             = sum_add;
                n_seen            = seen_inc;
                if ({1'b0, seen_inc} + LEN_MIN >= {1'b0, r_len}) begin
                    n_state = ST_CKSUM;
                end
            end
            ST_CKSUM: begin
                o_res_valid = 1'b1;
                o_res.kind  = (i_byte == r_sum) ? KIND_GOOD : KIND_BAD;
                n_state     = ST_HUNT;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/sld_out_stage.sv
// result register toward the master side
`default_nettype none

module sld_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire logic          i_res_valid,
    input  wire sld_pkg::t_result i_res,
    input  wire logic          i_ready,
    output logic               o_free,
    output logic               o_valid,
    output sld_pkg::t_result   o_res
);
    import sld_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or the held beat leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> hdl/sync_length_frame_deframer.sv
// top level of the sync length frame deframer
//
//  channel   dir  tdata fields (low bit up)                           tuser
//  s (rx)    in   rx_byte[7:0]                                        -
//  m (out)   out  command[7:0] param_count[14:8] param_index[21:15]   kind[1:0]
//                 data[29:22], zero[31:30]
//
// one byte per cycle sustained while the master keeps tready high; a byte waits in the
// input register and its result, if any, is loaded into the result register as the byte is taken
// the parse state advances only when the result register can take a beat
// synchronous active-low reset returns the parser to header hunt
// a stalled master holds the input side once both registers are full
`default_nettype none

module sync_length_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,    // command, param_count, param_index, data, pad
    output logic [1:0]       o_m_tuser     // kind
);
    import sld_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign step = in_valid && out_free;

    sld_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .o_valid (in_valid),
        .i_take  (step),
        .o_byte  (in_byte)
    );

    sld_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sld_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (i_m_tready),
        .o_free      (out_free),
        .o_valid     (o_m_tvalid),
        .o_res       (out_res)
    );

    assign o_m_tdata = {2'b00, out_res.data, out_res.param_index,
                        out_res.param_count, out_res.command};
    assign o_m_tuser = out_res.kind;

endmodule

`default_nettype wire
